[rtl/assert_macros.svh]
// Assertion macros shared by the RTL files. Each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check cons in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/i2cbs_pkg.sv]
`default_nettype none

package i2cbs_pkg;

  // Command codes as they arrive on the cmd port
  typedef enum logic [2:0] {
    CMD_START    = 3'd0,
    CMD_STOP     = 3'd1,
    CMD_WRITE    = 3'd2,
    CMD_WAIT_ACK = 3'd3,
    CMD_READ     = 3'd4
  } cmd_t;

  // Hold unit length after reset, in clock cycles
  localparam logic [15:0] UNIT_TICKS_RST = 16'd100;

  // Command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // Segment index within one command
  localparam int SEG_W = 5;
  localparam logic [SEG_W-1:0] SEG_SHORT_LAST = 5'd2;   // start, stop, wait ack
  localparam logic [SEG_W-1:0] SEG_WRITE_LAST = 5'd17;
  localparam logic [SEG_W-1:0] SEG_READ_TURN  = 5'd16;  // SCL low before master ack
  localparam logic [SEG_W-1:0] SEG_READ_ACK   = 5'd17;
  localparam logic [SEG_W-1:0] SEG_READ_CLK   = 5'd18;
  localparam logic [SEG_W-1:0] SEG_READ_LAST  = 5'd19;

  // Hold time codes in hold units (unit_ticks clock cycles each)
  localparam logic [1:0] HOLD_NONE = 2'd0;
  localparam logic [1:0] HOLD_ONE  = 2'd1;
  localparam logic [1:0] HOLD_TWO  = 2'd2;

  // Classified command held in the queue
  typedef struct packed {
    cmd_t       op;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic [7:0] line_bits;
    logic       ack_line;
  } cmd_entry_t;

  // Queue fill status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Bus line state kept between commands
  typedef struct packed {
    logic scl;
    logic sda;
    logic sim;  // SDA released to the slave
  } bus_state_t;

  // One bus segment as delivered
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_released;
    logic [1:0] hold_units;
    logic [7:0] rx_byte;
    logic       status;
    logic       last;
  } seg_t;

endpackage

`default_nettype wire

[rtl/i2c_master_bit_sequencer.sv]
// The first segment of a command is registered in the back end once the command
// leaves the queue. Throughput: one segment per cycle with out_ready high; a command
// has 3 (start, stop, wait ack on ACK), 2 (wait ack on NACK), 18 (write) or 20
// (read) segments, set by the segment sequencer in the back end.
// Reset (rst, synchronous): queue empty, SCL and SDA released high,
// unit_ticks back to 100.
`default_nettype none
`include "assert_macros.svh"

module i2c_master_bit_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  cmd,
  input  wire logic [7:0]  tx_byte,
  input  wire logic        send_ack,
  input  wire logic [7:0]  line_bits,
  input  wire logic        ack_line,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             scl_level,
  output logic             sda_level,
  output logic             sda_released,
  output logic [1:0]       hold_units,
  output logic [7:0]       rx_byte,
  output logic             status,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic [15:0]             unit_ticks;
  logic                    push;
  logic                    pop;
  i2cbs_pkg::cmd_entry_t   push_entry;
  i2cbs_pkg::cmd_entry_t   head;
  i2cbs_pkg::q_status_t    q_stat;
  i2cbs_pkg::seg_t         seg_out;

  // Store the hold unit length; sequencing does not depend on it
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks <= i2cbs_pkg::UNIT_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unit_ticks <= cfg_data;
    end
  end

  i2cbs_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .tx_byte    (tx_byte),
    .send_ack   (send_ack),
    .line_bits  (line_bits),
    .ack_line   (ack_line),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  i2cbs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  i2cbs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .seg_out   (seg_out)
  );

  assign scl_level    = seg_out.scl_level;
  assign sda_level    = seg_out.sda_level;
  assign sda_released = seg_out.sda_released;
  assign hold_units   = seg_out.hold_units;
  assign rx_byte      = seg_out.rx_byte;
  assign status       = seg_out.status;
  assign last         = seg_out.last;

  `ASSERT_NEXT(a_ticks_write, cfg_valid && cfg_ready, unit_ticks == $past(cfg_data))

endmodule

`default_nettype wire

[rtl/i2cbs_front.sv]
`default_nettype none

module i2cbs_front (
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [2:0]             cmd,
  input  wire logic [7:0]             tx_byte,
  input  wire logic                   send_ack,
  input  wire logic [7:0]             line_bits,
  input  wire logic                   ack_line,
  input  wire i2cbs_pkg::q_status_t   q_stat,
  output logic                        push,
  output i2cbs_pkg::cmd_entry_t       push_entry
);

  logic known;

  // Classify the command; unknown codes are taken and dropped
  always_comb begin
    case (cmd)
      i2cbs_pkg::CMD_START,
      i2cbs_pkg::CMD_STOP,
      i2cbs_pkg::CMD_WRITE,
      i2cbs_pkg::CMD_WAIT_ACK,
      i2cbs_pkg::CMD_READ: known = 1'b1;
      default:             known = 1'b0;
    endcase
  end

  // Accept whenever the queue has room
  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready && known;

  // Pack the fields for the back end
  always_comb begin
    push_entry.op        = i2cbs_pkg::cmd_t'(cmd);
    push_entry.tx_byte   = tx_byte;
    push_entry.send_ack  = send_ack;
    push_entry.line_bits = line_bits;
    push_entry.ack_line  = ack_line;
  end

endmodule

`default_nettype wire

[rtl/i2cbs_queue.sv]
`default_nettype none

module i2cbs_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire i2cbs_pkg::cmd_entry_t  push_entry,
  input  wire logic                   pop,
  output i2cbs_pkg::cmd_entry_t       head,
  output i2cbs_pkg::q_status_t        q_stat
);

  i2cbs_pkg::cmd_entry_t              mem [i2cbs_pkg::Q_DEPTH];
  logic [i2cbs_pkg::QPTR_W-1:0]       wr_ptr;
  logic [i2cbs_pkg::QPTR_W-1:0]       rd_ptr;
  logic [i2cbs_pkg::QCNT_W-1:0]       count;

  function automatic logic [i2cbs_pkg::QPTR_W-1:0] ptr_inc(
    input logic [i2cbs_pkg::QPTR_W-1:0] p
  );
    if (p == i2cbs_pkg::QPTR_W'(i2cbs_pkg::Q_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign q_stat.full  = (count == i2cbs_pkg::QCNT_W'(i2cbs_pkg::Q_DEPTH));
  assign q_stat.empty = (count == '0);
  assign head         = mem[rd_ptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

[rtl/i2cbs_back.sv]
`default_nettype none
`include "assert_macros.svh"

module i2cbs_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire i2cbs_pkg::cmd_entry_t  head,
  input  wire i2cbs_pkg::q_status_t   q_stat,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output i2cbs_pkg::seg_t             seg_out
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                         state;
  i2cbs_pkg::cmd_entry_t          cur;
  logic [i2cbs_pkg::SEG_W-1:0]    seg_idx;
  i2cbs_pkg::bus_state_t          bus;

  i2cbs_pkg::cmd_entry_t          sel;
  logic [i2cbs_pkg::SEG_W-1:0]    idx;
  logic [i2cbs_pkg::SEG_W-1:0]    wk;
  logic                           running;
  logic                           have;
  logic                           emit;
  i2cbs_pkg::bus_state_t          bus_next;
  logic [1:0]                     hold;
  logic [7:0]                     rx;
  logic                           status;
  logic                           fin;
  i2cbs_pkg::seg_t                seg_next;

  // Pick the running command or the queue head
  assign running = (state == ST_RUN);
  assign sel     = running ? cur : head;
  assign idx     = running ? seg_idx : '0;
  assign wk      = idx - 1'b1;
  assign have    = running || !q_stat.empty;
  assign emit    = have && (!out_valid || out_ready);
  assign pop     = emit && !running;

  // Work out the line state of this segment
  always_comb begin
    bus_next = bus;
    hold     = i2cbs_pkg::HOLD_NONE;
    rx       = 8'd0;
    status   = 1'b0;
    fin      = 1'b0;
    case (sel.op)
      i2cbs_pkg::CMD_START,
      i2cbs_pkg::CMD_STOP: begin
        hold = i2cbs_pkg::HOLD_TWO;
        if (idx == '0) begin
          bus_next.sim = 1'b0;
          bus_next.sda = (sel.op == i2cbs_pkg::CMD_START);
        end else if (idx == i2cbs_pkg::SEG_SHORT_LAST) begin
          bus_next.sda = (sel.op == i2cbs_pkg::CMD_STOP);
          fin          = 1'b1;
        end else begin
          bus_next.scl = 1'b1;
        end
      end
      i2cbs_pkg::CMD_WRITE: begin
        hold = i2cbs_pkg::HOLD_ONE;
        if (idx == '0) begin
          bus_next.sim = 1'b0;
        end else if (idx == i2cbs_pkg::SEG_WRITE_LAST) begin
          bus_next.scl = 1'b0;
          hold         = i2cbs_pkg::HOLD_NONE;
          fin          = 1'b1;
        end else if (!wk[0]) begin
          bus_next.scl = 1'b0;
          bus_next.sda = sel.tx_byte[~wk[3:1]];
        end else begin
          bus_next.scl = 1'b1;
        end
      end
      i2cbs_pkg::CMD_WAIT_ACK: begin
        hold = i2cbs_pkg::HOLD_ONE;
        if (idx == '0) begin
          bus_next.sda = 1'b1;
          bus_next.sim = 1'b1;
        end else if (idx == i2cbs_pkg::SEG_SHORT_LAST) begin
          bus_next.scl = 1'b0;
          hold         = i2cbs_pkg::HOLD_NONE;
          fin          = 1'b1;
        end else begin
          bus_next.scl = 1'b1;
          status       = sel.ack_line;
          fin          = sel.ack_line;
        end
      end
      i2cbs_pkg::CMD_READ: begin
        if (idx < i2cbs_pkg::SEG_READ_TURN) begin
          bus_next.sda = 1'b1;
          bus_next.sim = 1'b1;
          bus_next.scl = idx[0];
          hold         = idx[0] ? i2cbs_pkg::HOLD_TWO : i2cbs_pkg::HOLD_ONE;
        end else if (idx == i2cbs_pkg::SEG_READ_TURN) begin
          bus_next.scl = 1'b0;
        end else if (idx == i2cbs_pkg::SEG_READ_ACK) begin
          bus_next.sim = 1'b0;
          bus_next.sda = !sel.send_ack;
          hold         = i2cbs_pkg::HOLD_ONE;
        end else if (idx == i2cbs_pkg::SEG_READ_CLK) begin
          bus_next.scl = 1'b1;
          hold         = i2cbs_pkg::HOLD_ONE;
        end else begin
          bus_next.scl = 1'b0;
          rx           = sel.line_bits;
          fin          = 1'b1;
        end
      end
      default: begin
        fin = 1'b1;
      end
    endcase
  end

  // Form the delivered segment from the new line state
  always_comb begin
    seg_next.scl_level    = bus_next.scl;
    seg_next.sda_level    = bus_next.sim | bus_next.sda;
    seg_next.sda_released = bus_next.sim;
    seg_next.hold_units   = hold;
    seg_next.rx_byte      = rx;
    seg_next.status       = status;
    seg_next.last         = fin;
  end

  // Sequence segments and hold the output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seg_idx   <= '0;
      out_valid <= 1'b0;
      bus       <= '{scl: 1'b1, sda: 1'b1, sim: 1'b1};
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        bus       <= bus_next;
        if (fin) begin
          state <= ST_IDLE;
        end else begin
          state   <= ST_RUN;
          seg_idx <= idx + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (emit) begin
      seg_out <= seg_next;
      if (!fin) begin
        cur <= sel;
      end
    end
  end

  `ASSERT_IMPL(a_status_on_last, out_valid && seg_out.status, seg_out.last && seg_out.scl_level)
  `ASSERT_IMPL(a_rx_on_last, out_valid && (seg_out.rx_byte != 8'd0), seg_out.last)
  `ASSERT_IMPL(a_seg_range, running, seg_idx <= i2cbs_pkg::SEG_READ_LAST)
  `ASSERT_NEXT(a_pop_starts, pop && !fin, running && (seg_idx == 5'd1))

endmodule

`default_nettype wire

[sim/i2c_segment_checker.sv]
`timescale 1ns / 100ps

module i2c_segment_checker
  import i2cbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [2:0]  cmd,
  input  wire logic [7:0]  tx_byte,
  input  wire logic        send_ack,
  input  wire logic [7:0]  line_bits,
  input  wire logic        ack_line,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        scl_level,
  input  wire logic        sda_level,
  input  wire logic        sda_released,
  input  wire logic [1:0]  hold_units,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        status,
  input  wire logic        last,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [15:0] cfg_data,
  output int               mismatches,
  output int               pending
);

  // Bus line state carried from one command to the next
  bus_state_t  bus;
  logic [15:0] unit_ticks;
  seg_t        expected_segs[$];
  int          seg_count;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: segment %0d: %s", $time, seg_count, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Append one segment at the current line levels
  task automatic push_seg(input logic [1:0] hold, input logic [7:0] rx,
                          input logic st, input logic fin);
    seg_t s;
    s.scl_level    = bus.scl;
    s.sda_level    = bus.sim ? 1'b1 : bus.sda;
    s.sda_released = bus.sim;
    s.hold_units   = hold;
    s.rx_byte      = rx;
    s.status       = st;
    s.last         = fin;
    expected_segs.push_back(s);
  endtask

  // Expand one command into its bus segments
  task automatic expand_command(input logic [2:0] op, input logic [7:0] tx,
                                input logic ack, input logic [7:0] bits,
                                input logic ackl);
    logic [7:0] rx;
    rx = '0;
    case (op)
      CMD_START: begin
        bus.sim = 1'b0;
        bus.sda = 1'b1;
        push_seg(HOLD_TWO, '0, 1'b0, 1'b0);
        bus.scl = 1'b1;
        push_seg(HOLD_TWO, '0, 1'b0, 1'b0);
        bus.sda = 1'b0;
        push_seg(HOLD_TWO, '0, 1'b0, 1'b1);
      end
      CMD_STOP: begin
        bus.sim = 1'b0;
        bus.sda = 1'b0;
        push_seg(HOLD_TWO, '0, 1'b0, 1'b0);
        bus.scl = 1'b1;
        push_seg(HOLD_TWO, '0, 1'b0, 1'b0);
        bus.sda = 1'b1;
        push_seg(HOLD_TWO, '0, 1'b0, 1'b1);
      end
      CMD_WRITE: begin
        bus.sim = 1'b0;
        push_seg(HOLD_ONE, '0, 1'b0, 1'b0);
        for (int i = 7; i >= 0; i--) begin
          bus.scl = 1'b0;
          bus.sda = tx[i];
          push_seg(HOLD_ONE, '0, 1'b0, 1'b0);
          bus.scl = 1'b1;
          push_seg(HOLD_ONE, '0, 1'b0, 1'b0);
        end
        bus.scl = 1'b0;
        push_seg(HOLD_NONE, '0, 1'b0, 1'b1);
      end
      CMD_WAIT_ACK: begin
        bus.sda = 1'b1;
        bus.sim = 1'b1;
        push_seg(HOLD_ONE, '0, 1'b0, 1'b0);
        bus.scl = 1'b1;
        // NACK ends the command with SCL left high
        if (ackl) begin
          push_seg(HOLD_ONE, '0, 1'b1, 1'b1);
        end else begin
          push_seg(HOLD_ONE, '0, 1'b0, 1'b0);
          bus.scl = 1'b0;
          push_seg(HOLD_NONE, '0, 1'b0, 1'b1);
        end
      end
      CMD_READ: begin
        bus.sda = 1'b1;
        bus.sim = 1'b1;
        for (int i = 7; i >= 0; i--) begin
          bus.scl = 1'b0;
          push_seg(HOLD_ONE, '0, 1'b0, 1'b0);
          bus.scl = 1'b1;
          push_seg(HOLD_TWO, '0, 1'b0, 1'b0);
          rx = {rx[6:0], bits[i]};
        end
        bus.scl = 1'b0;
        push_seg(HOLD_NONE, '0, 1'b0, 1'b0);
        bus.sim = 1'b0;
        bus.sda = ~ack;
        push_seg(HOLD_ONE, '0, 1'b0, 1'b0);
        bus.scl = 1'b1;
        push_seg(HOLD_ONE, '0, 1'b0, 1'b0);
        bus.scl = 1'b0;
        push_seg(HOLD_NONE, rx, 1'b0, 1'b1);
      end
      default: ;
    endcase
  endtask

  // Predict on each command transfer, compare on each segment transfer
  always @(posedge clk) begin
    seg_t want;
    if (rst) begin
      bus.scl = 1'b1;
      bus.sda = 1'b1;
      bus.sim = 1'b1;
      unit_ticks = 16'd100;
      expected_segs.delete();
      mismatches = 0;
      seg_count = 0;
    end else begin
      if (cfg_valid && cfg_ready)
        unit_ticks = cfg_data;
      if (in_valid && in_ready)
        expand_command(cmd, tx_byte, send_ack, line_bits, ack_line);
      if (out_valid && out_ready) begin
        if (expected_segs.size() == 0) begin
          report_mismatch("segment with none expected");
        end else begin
          want = expected_segs.pop_front();
          check_field("scl_level", scl_level, want.scl_level);
          check_field("sda_level", sda_level, want.sda_level);
          check_field("sda_released", sda_released, want.sda_released);
          check_field("hold_units", hold_units, want.hold_units);
          check_field("rx_byte", rx_byte, want.rx_byte);
          check_field("status", status, want.status);
          check_field("last", last, want.last);
        end
        seg_count++;
      end
    end
    pending <= expected_segs.size();
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
  import i2cbs_pkg::*;

  localparam int RESET_CYCLES  = 12;
  localparam int DRAIN_CYCLES  = 10;
  localparam int END_CYCLES    = 20;
  localparam int STALL_CYCLES  = 300;
  localparam int WATCHDOG_MAX  = 5000;
  localparam int RANDOM_ITEMS  = 150;
  localparam int IDLE_PERCENT  = 21;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  cmd;
  logic [7:0]  tx_byte;
  logic        send_ack;
  logic [7:0]  line_bits;
  logic        ack_line;
  logic        out_valid;
  logic        out_ready;
  logic        scl_level;
  logic        sda_level;
  logic        sda_released;
  logic [1:0]  hold_units;
  logic [7:0]  rx_byte;
  logic        status;
  logic        last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  int   mismatches;
  int   pending;
  int   sent;
  int   idle_cycles;
  int   stall_left;
  logic quiet;
  logic stall_req;
  logic stall_done;

  i2c_master_bit_sequencer i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .tx_byte(tx_byte), .send_ack(send_ack),
    .line_bits(line_bits), .ack_line(ack_line),
    .out_valid(out_valid), .out_ready(out_ready),
    .scl_level(scl_level), .sda_level(sda_level), .sda_released(sda_released),
    .hold_units(hold_units), .rx_byte(rx_byte), .status(status), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  i2c_segment_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .tx_byte(tx_byte), .send_ack(send_ack),
    .line_bits(line_bits), .ack_line(ack_line),
    .out_valid(out_valid), .out_ready(out_ready),
    .scl_level(scl_level), .sda_level(sda_level), .sda_released(sda_released),
    .hold_units(hold_units), .rx_byte(rx_byte), .status(status), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = '0;
    tx_byte = '0;
    send_ack = 1'b0;
    line_bits = '0;
    ack_line = 1'b0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    quiet = 1'b0;
    stall_req = 1'b0;
    stall_done = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    sent = 0;
  end

  always #4 clk = ~clk;

  // Drop out_ready at random; hold it off once for a long stretch
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (stall_req && !stall_done) begin
      stall_left <= STALL_CYCLES;
      stall_done <= 1'b1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_MAX);
      $display("** i2c_master_bit_sequencer: FAILED **");
      $finish;
    end
  end

  // Offer one command and hold it until the transfer
  task automatic send_cmd(input logic [2:0] c, input logic [7:0] tx, input logic ack,
                          input logic [7:0] bits, input logic ackl);
    int gap;
    gap = (!quiet && $urandom_range(99) < IDLE_PERCENT) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    tx_byte   <= tx;
    send_ack  <= ack;
    line_bits <= bits;
    ack_line  <= ackl;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Stop offering and wait until every segment has come out
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_unit_ticks(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_data  <= $urandom;
    @(posedge clk);
  endtask

  initial begin
    int n_extra;
    int roll;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_unit_ticks(16'd1);

    // Directed: each command, byte extremes, ACK and NACK both ways
    send_cmd(CMD_START, $urandom, $urandom, $urandom, $urandom);
    send_cmd(CMD_WRITE, 8'h00, $urandom, $urandom, $urandom);
    send_cmd(CMD_WAIT_ACK, $urandom, $urandom, $urandom, 1'b0);
    send_cmd(CMD_WRITE, 8'hFF, $urandom, $urandom, $urandom);
    send_cmd(CMD_WAIT_ACK, $urandom, $urandom, $urandom, 1'b1);
    send_cmd(CMD_WRITE, 8'hA5, $urandom, $urandom, $urandom);
    send_cmd(CMD_READ, $urandom, 1'b1, 8'h00, $urandom);
    send_cmd(CMD_READ, $urandom, 1'b1, 8'hFF, $urandom);
    send_cmd(CMD_READ, $urandom, 1'b0, 8'h5A, $urandom);
    send_cmd(CMD_STOP, $urandom, $urandom, $urandom, $urandom);
    // Unknown codes must be ignored
    for (int c = CMD_READ + 1; c < 8; c++)
      send_cmd(c[2:0], $urandom, $urandom, $urandom, $urandom);
    send_cmd(CMD_WAIT_ACK, $urandom, $urandom, $urandom, 1'b1);
    send_cmd(CMD_READ, $urandom, 1'b0, 8'hC3, $urandom);
    send_cmd(CMD_START, $urandom, $urandom, $urandom, $urandom);
    send_cmd(CMD_STOP, $urandom, $urandom, $urandom, $urandom);
    send_cmd(CMD_STOP, $urandom, $urandom, $urandom, $urandom);
    drain();

    write_unit_ticks(16'hFFFF);

    // Random: mostly framed transactions, some loose commands as noise
    while (sent < RANDOM_ITEMS) begin
      if (sent >= RANDOM_ITEMS / 5 && !stall_done)
        stall_req <= 1'b1;
      quiet = (sent >= RANDOM_ITEMS / 2) && (sent < RANDOM_ITEMS * 3 / 4);
      if (sent >= RANDOM_ITEMS / 2 && sent < RANDOM_ITEMS / 2 + 8 && pending == 0) begin
        drain();
        write_unit_ticks($urandom_range(1, 16'hFFFF));
      end
      roll = $urandom_range(99);
      if (roll < 15) begin
        send_cmd($urandom_range(7), $urandom, $urandom, $urandom, $urandom);
      end else begin
        send_cmd(CMD_START, $urandom, $urandom, $urandom, $urandom);
        send_cmd(CMD_WRITE, $urandom, $urandom, $urandom, $urandom);
        send_cmd(CMD_WAIT_ACK, $urandom, $urandom, $urandom, $urandom_range(99) < 15);
        n_extra = $urandom_range(0, 3);
        for (int k = 0; k < n_extra; k++) begin
          if ($urandom_range(1)) begin
            send_cmd(CMD_WRITE, $urandom, $urandom, $urandom, $urandom);
            send_cmd(CMD_WAIT_ACK, $urandom, $urandom, $urandom,
                     $urandom_range(99) < 15);
          end else begin
            // ACK unless this is the final item of the run, inverted at random one time in ten
            send_cmd(CMD_READ, $urandom, (k != n_extra - 1) ^ ($urandom_range(9) == 0),
                     $urandom, $urandom);
          end
        end
        send_cmd(CMD_STOP, $urandom, $urandom, $urandom, $urandom);
      end
    end
    quiet = 1'b0;
    drain();

    write_unit_ticks(16'd100);
    repeat (END_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending == 0)
      $display("** i2c_master_bit_sequencer: PASSED **");
    else
      $display("** i2c_master_bit_sequencer: FAILED **");
    $finish;
  end

endmodule

[i2c_master_bit_sequencer.f]
+incdir+rtl
rtl/i2cbs_pkg.sv
rtl/i2cbs_front.sv
rtl/i2cbs_queue.sv
rtl/i2cbs_back.sv
rtl/i2c_master_bit_sequencer.sv
sim/i2c_segment_checker.sv
sim/tb.sv
